// File: rtl/pwc_pkg.sv
// shared constants and op codes for the pixel write combiner
`default_nettype none
package pwc_pkg;

  // field widths
  localparam int ADDR_W = 24;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 6;

  // default data bytes one burst buffer can hold
  localparam int DEF_MAX_BURST = 32;

  // burst limit after reset
  localparam logic [CFG_W-1:0] RESET_LIMIT = 6'd24;

  // serial memory write command
  localparam logic [BYTE_W-1:0] WRITE_CMD = 8'h02;

  // item op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

endpackage
`default_nettype wire

// File: rtl/pixel_write_combiner.sv
// top level of the pixel write combiner
//
// Combines single byte writes to a serial memory into bursts.
// Input channel (in_valid/in_stall): op, address, colour. op write appends
// colour to the open burst when address continues it; otherwise, or when
// the burst has reached burst_limit (zero as one, at most MAX_BURST) bytes,
// the open burst is flushed first. op flush sends the open burst, if any.
// Output channel (out_valid/out_stall): one spi_byte per item: command 0x02,
// three address bytes msb first, then data; burst_end marks the last byte.
// Config: cfg_write loads cfg_data into burst_limit (reset 24); write it
// only while the block is idle.
// Throughput: a write that extends the burst is taken without a stall. The
// sequencer sends header bytes at one per cycle unless out_stall holds it;
// each data byte waits on the registered read of the burst buffer memory.
// A flushed burst goes through the queue, then the idle and header states.
// The front may fill one buffer while the other drains; an item that needs
// a flush stalls while the previous burst is still being sent.
// Out_stall holds the output register and the sequencer; reset empties the
// queue, drops any open burst and restores the default limit.
`default_nettype none
module pixel_write_combiner #(
  parameter int MAX_BURST = pwc_pkg::DEF_MAX_BURST
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [pwc_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       op,
  input  wire logic [pwc_pkg::ADDR_W-1:0] address,
  input  wire logic [pwc_pkg::BYTE_W-1:0] colour,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [pwc_pkg::BYTE_W-1:0]      spi_byte,
  output logic                            burst_end
);
  import pwc_pkg::*;

  localparam int CW = $clog2(MAX_BURST + 1);
  localparam int IW = $clog2(MAX_BURST);
  localparam int DW = 1 + ADDR_W + CW;

  logic              back_busy;
  logic              push;
  logic              desc_bank;
  logic [ADDR_W-1:0] desc_start;
  logic [CW-1:0]     desc_count;
  logic              mem_we;
  logic [IW:0]       mem_addr;
  logic [BYTE_W-1:0] mem_data;
  logic              q_pop;
  logic              q_valid;
  logic [DW-1:0]     q_data;

  // front end
  pwc_front #(
    .MAX_BURST (MAX_BURST),
    .CW        (CW),
    .IW        (IW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .address    (address),
    .colour     (colour),
    .back_busy  (back_busy),
    .push       (push),
    .desc_bank  (desc_bank),
    .desc_start (desc_start),
    .desc_count (desc_count),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_data   (mem_data)
  );

  // descriptor queue
  pwc_queue #(
    .DW (DW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({desc_bank, desc_start, desc_count}),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // back end
  pwc_back #(
    .MAX_BURST (MAX_BURST),
    .CW        (CW),
    .IW        (IW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_bank    (q_data[DW-1]),
    .q_start   (q_data[DW-2:CW]),
    .q_count   (q_data[CW-1:0]),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_data  (mem_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .spi_byte  (spi_byte),
    .burst_end (burst_end)
  );

endmodule
`default_nettype wire

// File: rtl/pwc_front.sv
// front end: accepts items, tracks the open burst and decides when to flush
`default_nettype none
module pwc_front #(
  parameter int MAX_BURST = pwc_pkg::DEF_MAX_BURST,
  parameter int CW        = $clog2(MAX_BURST + 1),
  parameter int IW        = $clog2(MAX_BURST)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [pwc_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      op,
  input  wire logic [pwc_pkg::ADDR_W-1:0] address,
  input  wire logic [pwc_pkg::BYTE_W-1:0] colour,
  input  wire logic                      back_busy,
  output logic                           push,
  output logic                           desc_bank,
  output logic [pwc_pkg::ADDR_W-1:0]     desc_start,
  output logic [CW-1:0]                  desc_count,
  output logic                           mem_we,
  output logic [IW:0]                    mem_addr,
  output logic [pwc_pkg::BYTE_W-1:0]     mem_data
);
  import pwc_pkg::*;

  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

  logic                 bank;
  logic [ADDR_W-1:0]    burst_start;
  logic [CW-1:0]        burst_count;
  logic [CFG_W-1:0]     burst_limit;

  logic [CMPW-1:0]      lim_ext;
  logic [CMPW-1:0]      eff_limit;
  logic [CMPW-1:0]      cnt_ext;
  logic                 contiguous;
  logic                 needs_flush;
  logic                 accept;
  logic [CW-1:0]        base;
  logic                 wbank;

  // effective limit: zero acts as one, clamp to buffer size
  always_comb begin
    lim_ext = CMPW'(burst_limit);
    cnt_ext = CMPW'(burst_count);
    if (lim_ext == '0) begin
      eff_limit = CMPW'(1);
    end else if (lim_ext > CMPW'(MAX_BURST)) begin
      eff_limit = CMPW'(MAX_BURST);
    end else begin
      eff_limit = lim_ext;
    end
  end

  // classify the item against the open burst
  assign contiguous  = ((burst_start + ADDR_W'(burst_count)) == address);
  assign needs_flush = (burst_count != '0) &&
                       ((op == OP_FLUSH) || !contiguous || (cnt_ext >= eff_limit));
  assign in_stall    = needs_flush && back_busy;
  assign accept      = in_valid && !in_stall;
  assign push        = accept && needs_flush;

  // where the byte lands: a flush switches to the other buffer
  assign base  = needs_flush ? '0 : burst_count;
  assign wbank = needs_flush ? ~bank : bank;

  assign mem_we   = accept && (op == OP_WRITE);
  assign mem_addr = {wbank, base[IW-1:0]};
  assign mem_data = colour;

  assign desc_bank  = bank;
  assign desc_start = burst_start;
  assign desc_count = burst_count;

  // open burst state and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      bank        <= 1'b0;
      burst_start <= '0;
      burst_count <= '0;
      burst_limit <= RESET_LIMIT;
    end else begin
      if (cfg_write) begin
        burst_limit <= cfg_data;
      end
      if (accept) begin
        bank <= wbank;
        if (op == OP_WRITE) begin
          if (base == '0) begin
            burst_start <= address;
          end
          burst_count <= base + CW'(1);
        end else begin
          burst_count <= '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/pwc_queue.sv
// two-entry burst descriptor queue between front and back
`default_nettype none
module pwc_queue #(
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  input  wire logic          pop,
  output logic               not_empty,
  output logic [DW-1:0]      pop_data
);
  import pwc_pkg::*;

  logic [DW-1:0] entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_push;
  logic          do_pop;

  assign not_empty = (fill != 2'd0);
  assign pop_data  = entry[rd_ptr];
  assign do_push   = push && (fill != 2'd2);
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/pwc_back.sv
// back end: burst buffers and the byte sequencer that sends each burst out
`default_nettype none
module pwc_back #(
  parameter int MAX_BURST = pwc_pkg::DEF_MAX_BURST,
  parameter int CW        = $clog2(MAX_BURST + 1),
  parameter int IW        = $clog2(MAX_BURST)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  input  wire logic                       q_bank,
  input  wire logic [pwc_pkg::ADDR_W-1:0] q_start,
  input  wire logic [CW-1:0]              q_count,
  output logic                            q_pop,
  output logic                            busy,
  input  wire logic                       mem_we,
  input  wire logic [IW:0]                mem_addr,
  input  wire logic [pwc_pkg::BYTE_W-1:0] mem_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [pwc_pkg::BYTE_W-1:0]      spi_byte,
  output logic                            burst_end
);
  import pwc_pkg::*;

  localparam int BUF_DEPTH = 2 ** (IW + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR,
    S_RD,
    S_DAT
  } state_t;

  state_t            state;
  logic              d_bank;
  logic [ADDR_W-1:0] d_start;
  logic [CW-1:0]     d_count;
  logic [IW-1:0]     idx;
  logic [1:0]        hcnt;

  logic [BYTE_W-1:0] mem [BUF_DEPTH];
  logic [BYTE_W-1:0] mem_q;
  logic [IW:0]       rd_addr;

  logic              can_load;
  logic              last_data;
  logic [BYTE_W-1:0] hdr_byte;

  // two burst buffers, one written by the front while the other drains
  assign rd_addr = {d_bank, idx};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_data;
    end
    mem_q <= mem[rd_addr];
  end

  assign busy      = q_valid || (state != S_IDLE);
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign can_load  = !out_valid || !out_stall;
  assign last_data = (CW'(idx) == (d_count - CW'(1)));

  // header byte select: command, then address msb first
  always_comb begin
    unique case (hcnt)
      2'd0:    hdr_byte = WRITE_CMD;
      2'd1:    hdr_byte = d_start[23:16];
      2'd2:    hdr_byte = d_start[15:8];
      default: hdr_byte = d_start[7:0];
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      d_bank    <= 1'b0;
      d_start   <= '0;
      d_count   <= '0;
      idx       <= '0;
      hcnt      <= 2'd0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            d_bank  <= q_bank;
            d_start <= q_start;
            d_count <= q_count;
            idx     <= '0;
            hcnt    <= 2'd0;
            state   <= S_HDR;
          end
        end
        S_HDR: begin
          if (can_load) begin
            out_valid <= 1'b1;
            spi_byte  <= hdr_byte;
            burst_end <= 1'b0;
            hcnt      <= hcnt + 2'd1;
            if (hcnt == 2'd3) begin
              state <= S_DAT;
            end
          end
        end
        S_RD: begin
          state <= S_DAT;
        end
        S_DAT: begin
          if (can_load) begin
            out_valid <= 1'b1;
            spi_byte  <= mem_q;
            burst_end <= last_data;
            if (last_data) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_pixel_write_combiner.sv
`timescale 1ns / 100ps
// self-checking testbench for the pixel write combiner burst stream
module tb_pixel_write_combiner;
  import pwc_pkg::*;

  localparam int MAX_BURST    = DEF_MAX_BURST;
  localparam int DRAIN_CYCLES = 12;
  localparam int DIR_ROWS     = 18;
  localparam int PHASE_ITEMS  = 6;
  localparam int LIMIT_STEPS  = 7;

  // one byte on the serial side
  typedef struct packed {
    logic              last;
    logic [BYTE_W-1:0] data;
  } spi_beat_t;

  // one input item, with the results typed in where they are obvious
  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] colour;
    logic              typed;
    logic [2:0]        n_exp;
    spi_beat_t [0:5]   exp;
  } stim_row_t;

  // directed items, walked after reset with the default limit
  stim_row_t dir_table [DIR_ROWS] = '{
    // flush with nothing buffered
    '{OP_FLUSH, 24'h000000, 8'h00, 1'b1, 3'd0, '0},
    // top address, then wrap to zero continues the burst
    '{OP_WRITE, 24'hffffff, 8'hff, 1'b1, 3'd0, '0},
    '{OP_WRITE, 24'h000000, 8'h00, 1'b1, 3'd0, '0},
    '{OP_FLUSH, 24'hffffff, 8'hff, 1'b1, 3'd6,
      {9'h0_02, 9'h0_ff, 9'h0_ff, 9'h0_ff, 9'h0_ff, 9'h1_00}},
    // a jump in address sends the open burst first
    '{OP_WRITE, 24'h000000, 8'h00, 1'b1, 3'd0, '0},
    '{OP_WRITE, 24'h123456, 8'ha5, 1'b1, 3'd5,
      {9'h0_02, 9'h0_00, 9'h0_00, 9'h0_00, 9'h1_00, 9'h0_00}},
    '{OP_WRITE, 24'h123457, 8'h5a, 1'b1, 3'd0, '0},
    '{OP_WRITE, 24'habcdef, 8'h3c, 1'b1, 3'd6,
      {9'h0_02, 9'h0_12, 9'h0_34, 9'h0_56, 9'h0_a5, 9'h1_5a}},
    '{OP_FLUSH, 24'h000000, 8'h00, 1'b1, 3'd5,
      {9'h0_02, 9'h0_ab, 9'h0_cd, 9'h0_ef, 9'h1_3c, 9'h0_00}},
    '{OP_FLUSH, 24'hffffff, 8'hff, 1'b1, 3'd0, '0},
    // mixed patterns, checked by the predictor
    '{OP_WRITE, 24'h800000, 8'h01, 1'b0, 3'd0, '0},
    '{OP_WRITE, 24'h800001, 8'h80, 1'b0, 3'd0, '0},
    '{OP_WRITE, 24'h7fffff, 8'h7e, 1'b0, 3'd0, '0},
    '{OP_WRITE, 24'h800000, 8'h81, 1'b0, 3'd0, '0},
    '{OP_WRITE, 24'h555555, 8'haa, 1'b0, 3'd0, '0},
    '{OP_FLUSH, 24'haaaaaa, 8'h55, 1'b0, 3'd0, '0},
    '{OP_WRITE, 24'haaaaaa, 8'h55, 1'b0, 3'd0, '0},
    '{OP_WRITE, 24'haaaaab, 8'hff, 1'b0, 3'd0, '0}
  };

  // limit settings for the phases after the default one
  logic [CFG_W-1:0] limit_plan [LIMIT_STEPS] = '{
    6'd32, 6'd0, 6'd63, 6'd1, 6'd45, 6'd0, 6'd8
  };

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_write = 1'b0;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic              op        = OP_WRITE;
  logic [ADDR_W-1:0] address   = '0;
  logic [BYTE_W-1:0] colour    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] spi_byte;
  logic              burst_end;

  // typed results that travel with the item on the input channel
  logic              row_typed = 1'b0;
  logic [2:0]        row_n     = '0;
  spi_beat_t [0:5]   row_exp   = '0;

  // predictor state
  logic [CFG_W-1:0]  limit_q;
  logic [BYTE_W-1:0] burst_mem [MAX_BURST];
  logic [ADDR_W-1:0] burst_base;
  int                burst_fill;
  spi_beat_t         burst_out [$];
  spi_beat_t         pending_spi [$];
  spi_beat_t         exp_beat;
  int                mismatch_count = 0;

  // stimulus state
  logic [ADDR_W-1:0] next_addr = '0;
  logic              calm      = 1'b0;
  int                items_sent = 0;
  int                hold_left  = 0;

  pixel_write_combiner DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .address   (address),
    .colour    (colour),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .spi_byte  (spi_byte),
    .burst_end (burst_end)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gap length: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // limit as the block applies it
  function automatic int eff_limit();
    if (limit_q == '0) return 1;
    if (int'(limit_q) > MAX_BURST) return MAX_BURST;
    return int'(limit_q);
  endfunction

  // send the open burst: command, address msb first, data
  task automatic flush_burst();
    if (burst_fill > 0) begin
      burst_out.push_back({1'b0, WRITE_CMD});
      burst_out.push_back({1'b0, burst_base[23:16]});
      burst_out.push_back({1'b0, burst_base[15:8]});
      burst_out.push_back({1'b0, burst_base[7:0]});
      for (int i = 0; i < burst_fill; i++)
        burst_out.push_back({(i + 1 == burst_fill), burst_mem[i]});
      burst_fill = 0;
    end
  endtask

  // bytes caused by one item
  task automatic combine_item(input logic op_i, input logic [ADDR_W-1:0] addr_i,
                              input logic [BYTE_W-1:0] col_i);
    logic [ADDR_W-1:0] next_a;
    burst_out.delete();
    if (op_i == OP_FLUSH) begin
      flush_burst();
    end else begin
      next_a = burst_base + ADDR_W'(burst_fill);
      if (burst_fill > 0 && (next_a != addr_i || burst_fill >= eff_limit()))
        flush_burst();
      if (burst_fill == 0) burst_base = addr_i;
      if (burst_fill < MAX_BURST) begin
        burst_mem[burst_fill] = col_i;
        burst_fill++;
      end
    end
  endtask

  // predictor and checker
  always @(posedge clk) begin
    if (rst) begin
      limit_q    = RESET_LIMIT;
      burst_base = '0;
      burst_fill = 0;
      pending_spi.delete();
    end else begin
      // register write
      if (cfg_write) limit_q = cfg_data;
      // accepted input item
      if (in_valid && !in_stall) begin
        combine_item(op, address, colour);
        if (row_typed) begin
          for (int i = 0; i < int'(row_n); i++) pending_spi.push_back(row_exp[i]);
        end else begin
          foreach (burst_out[i]) pending_spi.push_back(burst_out[i]);
        end
      end
      // accepted output item
      if (out_valid && !out_stall) begin
        if (pending_spi.size() == 0) begin
          $error("unexpected item: spi_byte %h burst_end %b", spi_byte, burst_end);
          mismatch_count++;
        end else begin
          exp_beat = pending_spi.pop_front();
          if (spi_byte !== exp_beat.data) begin
            $error("spi_byte: expected %h, actual %h", exp_beat.data, spi_byte);
            mismatch_count++;
          end
          if (burst_end !== exp_beat.last) begin
            $error("burst_end: expected %b, actual %b", exp_beat.last, burst_end);
            mismatch_count++;
          end
        end
      end
    end
  end

  // receiver stall: segments of random length, none while calm
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 2) == 0);
      hold_left <= gap_len();
    end
  end

  function automatic stim_row_t make_item(input logic op_i, input logic [ADDR_W-1:0] addr_i,
                                          input logic [BYTE_W-1:0] col_i);
    stim_row_t row;
    row        = '0;
    row.op     = op_i;
    row.addr   = addr_i;
    row.colour = col_i;
    return row;
  endfunction

  // drive one item and hold it until taken
  task automatic send_item(input stim_row_t row);
    int gap;
    in_valid  <= 1'b1;
    op        <= row.op;
    address   <= row.addr;
    colour    <= row.colour;
    row_typed <= row.typed;
    row_n     <= row.n_exp;
    row_exp   <= row.exp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // contiguous writes with random data
  task automatic write_run(input int len, input logic [ADDR_W-1:0] start);
    logic [BYTE_W-1:0] data;
    for (int i = 0; i < len; i++) begin
      data = BYTE_W'($urandom);
      send_item(make_item(OP_WRITE, start + ADDR_W'(i), data));
    end
    next_addr = start + ADDR_W'(len);
  endtask

  // flush with random don't-care fields
  task automatic send_flush();
    send_item(make_item(OP_FLUSH, ADDR_W'($urandom), BYTE_W'($urandom)));
  endtask

  // wait until every expected byte is out and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    // let the predictor take in the last accepted item first
    @(posedge clk);
    while (pending_spi.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // mostly contiguous runs, some flushes, some stray writes
  task automatic random_phase(input int target);
    int                start_cnt;
    int                r;
    int                len;
    logic [ADDR_W-1:0] start;
    bit                first;
    start_cnt = items_sent;
    first     = 1'b1;
    while (items_sent - start_cnt < target) begin
      r = $urandom_range(0, 99);
      if (first || r < 70) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, MAX_BURST + 4);
        else len = $urandom_range(1, eff_limit() + 2);
        if (first || $urandom_range(0, 2) == 0) start = next_addr;
        else if ($urandom_range(0, 7) == 0) start = 24'hffffff - ADDR_W'($urandom_range(0, 6));
        else start = ADDR_W'($urandom);
        write_run(len, start);
        if ($urandom_range(0, 3) == 0) send_flush();
        first = 1'b0;
      end else if (r < 85) begin
        send_flush();
      end else begin
        write_run(1, ADDR_W'($urandom));
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items at the reset limit
    foreach (dir_table[i]) send_item(dir_table[i]);
    next_addr = dir_table[DIR_ROWS-1].addr + 1'b1;
    random_phase(PHASE_ITEMS);

    // phases over several limits, sometimes with a burst left open
    limit_plan[5] = CFG_W'($urandom);
    for (int p = 0; p < LIMIT_STEPS; p++) begin
      if (!(p == 1 || $urandom_range(0, 2) == 0)) send_flush();
      set_limit(limit_plan[p]);
      calm = (p % 3 == 1);
      random_phase(PHASE_ITEMS);
    end
    calm = 1'b0;
    send_flush();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #7_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
